// File: src/srv_pkg.sv
// shared types and constants of the stored record validator
`default_nettype none

package srv_pkg;

  localparam int unsigned MAX_PAYLOAD = 4096;

  localparam int unsigned POS_W = 13;
  localparam int unsigned LEN_W = 13;
  localparam int unsigned SCHEMA_W = 16;
  localparam int unsigned CRC_W = 32;

  localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(16);
  localparam logic [POS_W-1:0] CRC_FIELD_POS = POS_W'(12);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [31:0] REC_MAGIC = 32'h4D4F_4F50;
  localparam logic [15:0] REC_FORMAT = 16'h0001;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ALL = 32'hFFFF_FFFF;

  typedef enum logic {
    REG_SCHEMA = 1'b0,
    REG_LENGTH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [SCHEMA_W-1:0] schema;
    logic [LEN_W-1:0]    length;
  } cfg_t;

  typedef struct packed {
    logic pay;
    logic done;
    logic ok;
  } result_t;

endpackage

`default_nettype wire

// File: src/stored_record_validator.sv
// Stored record validator: takes a record one byte per item (16-byte header, then payload),
// checks the header against the expected magic, format, schema and length, runs a
// reflected CRC-32 over the payload and flags the result on the last byte. One item is
// accepted every cycle while out_stall does not hold a result; each item goes through an
// input register and a result register, with the single-byte CRC update and header
// compare between them. Configuration writes are taken at any time through
// cfg_valid/cfg_ready and must be made only while no record item is in flight.
`default_nettype none

module stored_record_validator
  import srv_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          data_byte,
  input  wire logic                last_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               payload_byte,
  output logic                     is_payload,
  output logic                     done_res,
  output logic                     record_ok,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [SCHEMA_W-1:0] cfg_data
);

  cfg_t       cfg;
  result_t    res;
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       out_adv;
  logic       step;
  logic       in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.schema <= '0;
      cfg.length <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        REG_SCHEMA: cfg.schema <= cfg_data;
        REG_LENGTH: cfg.length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_adv = !out_valid || !out_stall;
  assign step = s1_valid && out_adv;
  assign in_stall = s1_valid && !out_adv;
  assign in_take = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
  end

  srv_track u_track (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .data (s1_data),
    .last (s1_last),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      payload_byte <= s1_data;
      is_payload <= res.pay;
      done_res <= res.done;
      record_ok <= res.ok;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with no item held");

  a_result_follows_step: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("result register not loaded after a step");

endmodule

`default_nettype wire

// File: src/srv_crc8.sv
// reflected crc-32 update over one byte
`default_nettype none

module srv_crc8
  import srv_pkg::*;
(
  input  wire logic [CRC_W-1:0] crc_in,
  input  wire logic [7:0]       data,
  output logic      [CRC_W-1:0] crc_out
);

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// File: src/srv_track.sv
// per-record state: position, header compare, crc capture and payload crc
`default_nettype none

module srv_track
  import srv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data,
  input  wire logic       last,
  input  wire cfg_t       cfg,
  output result_t         res
);

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic             header_mismatch;
  logic             header_mismatch_next;
  logic [CRC_W-1:0] running_crc;
  logic [CRC_W-1:0] running_crc_next;
  logic [CRC_W-1:0] stored_crc;
  logic [CRC_W-1:0] stored_crc_next;
  logic [CRC_W-1:0] crc_upd;

  logic             sat;
  logic             in_hdr;
  logic             in_crc;
  logic             past_hdr;
  logic             pay;
  logic [7:0]       expect_byte;
  logic [POS_W:0]   rec_end;
  logic             len_ok;

  srv_crc8 u_crc (
    .crc_in  (running_crc),
    .data    (data),
    .crc_out (crc_upd)
  );

  always_comb begin
    unique case (byte_position[3:0])
      4'd0:    expect_byte = REC_MAGIC[7:0];
      4'd1:    expect_byte = REC_MAGIC[15:8];
      4'd2:    expect_byte = REC_MAGIC[23:16];
      4'd3:    expect_byte = REC_MAGIC[31:24];
      4'd4:    expect_byte = REC_FORMAT[7:0];
      4'd5:    expect_byte = REC_FORMAT[15:8];
      4'd6:    expect_byte = cfg.schema[7:0];
      4'd7:    expect_byte = cfg.schema[15:8];
      4'd8:    expect_byte = cfg.length[7:0];
      4'd9:    expect_byte = {3'b000, cfg.length[12:8]};
      default: expect_byte = 8'h00;
    endcase
  end

  assign sat = (byte_position == POS_MAX);
  assign in_hdr = (byte_position < CRC_FIELD_POS);
  assign in_crc = !in_hdr && (byte_position < HDR_BYTES);
  assign past_hdr = !sat && !in_hdr && !in_crc;
  assign rec_end = {1'b0, HDR_BYTES} + {1'b0, cfg.length};
  assign pay = past_hdr && ({1'b0, byte_position} < rec_end);
  assign len_ok = (cfg.length != '0) && (32'(cfg.length) <= MAX_PAYLOAD);

  always_comb begin
    header_mismatch_next = header_mismatch;
    if (sat || (in_hdr && data != expect_byte) || (past_hdr && !pay)) begin
      header_mismatch_next = 1'b1;
    end
    stored_crc_next = stored_crc;
    if (in_crc) begin
      stored_crc_next[8*byte_position[1:0] +: 8] = data;
    end
    running_crc_next = pay ? crc_upd : running_crc;
    byte_position_next = sat ? byte_position : byte_position + POS_W'(1);
  end

  assign res.pay = pay;
  assign res.done = last;
  assign res.ok = last && !header_mismatch_next && len_ok
                  && ({1'b0, byte_position_next} == rec_end)
                  && ((running_crc_next ^ CRC_ALL) == stored_crc_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      header_mismatch <= 1'b0;
      running_crc <= CRC_ALL;
      stored_crc <= '0;
    end else if (step) begin
      if (last) begin
        byte_position <= '0;
        header_mismatch <= 1'b0;
        running_crc <= CRC_ALL;
        stored_crc <= '0;
      end else begin
        byte_position <= byte_position_next;
        header_mismatch <= header_mismatch_next;
        running_crc <= running_crc_next;
        stored_crc <= stored_crc_next;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last |=> byte_position == '0 && running_crc == CRC_ALL && !header_mismatch)
    else $error("record state not cleared after last item");

  a_ok_only_on_last: assert property (@(posedge clk) disable iff (rst)
    res.ok |-> res.done)
    else $error("record_ok without done");

  a_payload_after_header: assert property (@(posedge clk) disable iff (rst)
    step && res.pay |-> byte_position >= HDR_BYTES)
    else $error("payload flagged inside header");

  a_crc_only_on_payload: assert property (@(posedge clk) disable iff (rst)
    step && !last && !res.pay |=> $stable(running_crc))
    else $error("crc changed on a non-payload item");

endmodule

`default_nettype wire
